// File: rtl/core/klx_pkg.sv
// Shared types, constants and character-class helpers for the keyword/identifier lexer.
// Has no dependencies; every other lexer file imports it.
package klx_pkg;

    localparam int LENGTH_BITS   = 8;
    localparam int POSITION_BITS = 16;
    localparam int QDEPTH        = 4;
    localparam int QPTR_BITS     = $clog2(QDEPTH);
    localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        K_INT       = 4'd0,
        K_PRINT     = 4'd1,
        K_NUMBER    = 4'd2,
        K_ID        = 4'd3,
        K_ASSIGN    = 4'd4,
        K_MUL       = 4'd5,
        K_ADD       = 4'd6,
        K_LPAREN    = 4'd7,
        K_RPAREN    = 4'd8,
        K_SEMICOLON = 4'd9,
        K_EOF       = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_NUM  = 3'b010,
        PH_ID   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        CAND_NONE  = 2'd0,
        CAND_INT   = 2'd1,
        CAND_PRINT = 2'd2
    } cand_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } in_beat_t;

    typedef struct packed {
        kind_t                    kind;
        logic [POSITION_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0]   length;
        logic                     last;
    } out_beat_t;

    typedef struct packed {
        phase_t                   phase;
        cand_t                    cand;
        logic [2:0]               prog;
        logic [POSITION_BITS-1:0] run_start;
        logic [LENGTH_BITS-1:0]   run_len;
        logic [POSITION_BITS-1:0] char_pos;
    } lex_state_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c inside {"=", "*", "+", "(", ")", ";"});
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "=":     k = K_ASSIGN;
            "*":     k = K_MUL;
            "+":     k = K_ADD;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            ";":     k = K_SEMICOLON;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] kw_char(input cand_t cand, input logic [2:0] prog);
        logic [7:0] c;
        c = 8'h00;
        if (cand == CAND_INT) begin
            case (prog)
                3'd0:    c = "i";
                3'd1:    c = "n";
                3'd2:    c = "t";
                default: c = 8'h00;
            endcase
        end else begin
            case (prog)
                3'd0:    c = "p";
                3'd1:    c = "r";
                3'd2:    c = "i";
                3'd3:    c = "n";
                3'd4:    c = "t";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// File: rtl/core/klx_step.sv
// Per-character lexer step: next run state and up to two tokens for one input beat.
// Depends on klx_pkg.
module klx_step (
    input  klx_pkg::lex_state_t st,
    input  klx_pkg::in_beat_t   beat,
    output klx_pkg::lex_state_t st_next,
    output logic [1:0]          tok_count,
    output klx_pkg::out_beat_t  tok0,
    output klx_pkg::out_beat_t  tok1
);
    import klx_pkg::*;

    logic [7:0]               c;
    logic [POSITION_BITS-1:0] pos;
    logic                     flush_v;
    logic                     start_v;
    logic                     second_v;
    out_beat_t                flush_tok;
    out_beat_t                second_tok;
    logic [LENGTH_BITS-1:0]   grown_len;
    logic [2:0]               kw_len;
    logic                     kw_hit;
    logic                     kw_done;

    always_comb begin
        c         = beat.ch;
        pos       = st.char_pos;
        grown_len = (st.run_len == {LENGTH_BITS{1'b1}}) ? st.run_len
                                                       : st.run_len + 1'b1;
        kw_len    = (st.cand == CAND_INT) ? 3'd3 : 3'd5;
        kw_hit    = (st.cand != CAND_NONE) && (st.prog < kw_len)
                    && (c == kw_char(st.cand, st.prog));
        kw_done   = ((st.prog + 3'd1) == kw_len);

        st_next    = st;
        flush_v    = 1'b0;
        start_v    = 1'b0;
        second_v   = 1'b0;
        second_tok = '0;

        if (beat.mode) begin
            flush_v                 = (st.phase != PH_IDLE);
            second_v                = 1'b1;
            second_tok.kind         = K_EOF;
            second_tok.start_offset = pos;
            second_tok.length       = '0;
        end else begin
            st_next.char_pos = pos + 1'b1;
            case (st.phase)
                PH_NUM: begin
                    if (is_digit(c)) begin
                        st_next.run_len = grown_len;
                    end else begin
                        flush_v = 1'b1;
                        start_v = 1'b1;
                    end
                end
                PH_ID: begin
                    if (kw_hit) begin
                        st_next.prog    = st.prog + 3'd1;
                        st_next.run_len = grown_len;
                        if (kw_done) begin
                            second_v                = 1'b1;
                            second_tok.kind         = (st.cand == CAND_INT) ? K_INT : K_PRINT;
                            second_tok.start_offset = st.run_start;
                            second_tok.length       = LENGTH_BITS'(kw_len);
                            st_next.phase           = PH_IDLE;
                            st_next.cand            = CAND_NONE;
                            st_next.prog            = '0;
                            st_next.run_len         = '0;
                        end
                    end else if (is_alpha(c) || is_digit(c)) begin
                        st_next.cand    = CAND_NONE;
                        st_next.prog    = '0;
                        st_next.run_len = grown_len;
                    end else begin
                        flush_v = 1'b1;
                        start_v = 1'b1;
                    end
                end
                default: begin
                    start_v = 1'b1;
                end
            endcase
        end

        if (flush_v) begin
            st_next.phase   = PH_IDLE;
            st_next.cand    = CAND_NONE;
            st_next.prog    = '0;
            st_next.run_len = '0;
        end

        if (start_v) begin
            if (is_digit(c) || is_alpha(c)) begin
                st_next.phase     = is_digit(c) ? PH_NUM : PH_ID;
                st_next.run_start = pos;
                st_next.run_len   = LENGTH_BITS'(1);
                st_next.cand      = CAND_NONE;
                st_next.prog      = '0;
                if (c == "i") begin
                    st_next.cand = CAND_INT;
                    st_next.prog = 3'd1;
                end else if (c == "p") begin
                    st_next.cand = CAND_PRINT;
                    st_next.prog = 3'd1;
                end
            end else if (is_punct(c)) begin
                second_v                = 1'b1;
                second_tok.kind         = punct_kind(c);
                second_tok.start_offset = pos;
                second_tok.length       = LENGTH_BITS'(1);
            end
        end

        if (beat.mode) begin
            st_next = '{phase: PH_IDLE, cand: CAND_NONE, prog: '0,
                        run_start: '0, run_len: '0, char_pos: '0};
        end

        flush_tok.kind         = (st.phase == PH_NUM) ? K_NUMBER : K_ID;
        flush_tok.start_offset = st.run_start;
        flush_tok.length       = st.run_len;
        flush_tok.last         = !second_v;
        second_tok.last        = 1'b1;

        tok_count = {1'b0, flush_v} + {1'b0, second_v};
        tok0      = flush_v ? flush_tok : second_tok;
        tok1      = second_tok;
    end

endmodule

// File: rtl/core/klx_queue.sv
// Token queue: takes zero, one or two tokens per cycle, hands out one beat per cycle while m_ready is high.
// Depends on klx_pkg.
module klx_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_count,
    input  klx_pkg::out_beat_t push0,
    input  klx_pkg::out_beat_t push1,
    output logic               room2,
    output logic               m_valid,
    input  logic               m_ready,
    output klx_pkg::out_beat_t m_beat
);
    import klx_pkg::*;

    out_beat_t              q_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   pop;

    assign m_valid = (count_reg != '0);
    assign m_beat  = q_reg[rd_ptr_reg];
    assign room2   = (count_reg <= QCNT_BITS'(QDEPTH - 2));
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        count_next  = count_reg + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            q_reg[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QDEPTH))
        else $error("token queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> (({1'b0, count_reg} + (QCNT_BITS+1)'(push_count))
                                  <= (QCNT_BITS+1)'(QDEPTH)))
        else $error("token queue overflow");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (count_reg == '0))
        else $error("token queue not empty after reset");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == QPTR_BITS'(count_reg))
        else $error("token queue pointers disagree with count");

endmodule

// File: rtl/core/keyword_identifier_lexer.sv
// Top level of the keyword/identifier lexer: input register, run state, token queue.
// Depends on klx_pkg, klx_step and klx_queue.
//
//  port group   dir  beat type    meaning
//  s_*          in   in_beat_t    one character or end of text
//  m_*          out  out_beat_t   one token: kind, start offset, length, last
//
//  One character per cycle sustained while tokens drain at one per cycle; m_valid rises the
//  cycle after a beat advances from the input register into the token queue with a token.
//  A beat that yields two tokens (flush plus single-character token or EOF) queues both at
//  once; the four-entry token queue absorbs this, and s_ready drops only while the queue
//  lacks room for two tokens and a character is waiting in the input register.
//  Reset (aresetn low, synchronous) empties the input register and the queue and returns the
//  run state and character position to zero.
module keyword_identifier_lexer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  klx_pkg::in_beat_t  s_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output klx_pkg::out_beat_t m_beat
);
    import klx_pkg::*;

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    lex_state_t state_reg;
    lex_state_t state_next;
    logic [1:0] tok_count;
    out_beat_t  tok0;
    out_beat_t  tok1;
    logic       room2;
    logic       advance;

    assign advance = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || advance;

    klx_step u_step (
        .st        (state_reg),
        .beat      (in_beat_reg),
        .st_next   (state_next),
        .tok_count (tok_count),
        .tok0      (tok0),
        .tok1      (tok1)
    );

    klx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (advance ? tok_count : 2'd0),
        .push0      (tok0),
        .push1      (tok1),
        .room2      (room2),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_beat     (m_beat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_IDLE, cand: CAND_NONE, prog: '0,
                              run_start: '0, run_len: '0, char_pos: '0};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_beat;
        end
    end

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room2) |=> (in_valid_reg && $stable(state_reg)))
        else $error("input beat dropped while queue full");

    a_eof_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_beat_reg.mode) |=> (state_reg.char_pos == '0
                                           && state_reg.phase == PH_IDLE))
        else $error("end of text did not clear run state");

    a_prog_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.cand != CAND_NONE) |-> (state_reg.prog != 3'd0
                                           && state_reg.phase == PH_ID))
        else $error("keyword candidate outside identifier run");

endmodule
